FILE: hdl/pcd_pkg.sv
package pcd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned LenW   = 15;
  localparam int unsigned DiffW  = 17;
  localparam int unsigned ProdW  = 33;
  localparam int unsigned ProjW  = 35;
  localparam int unsigned OffW   = 32;
  localparam int unsigned RelW   = 18;
  localparam int unsigned MagW   = 17;
  localparam int unsigned SqW    = 34;
  localparam int unsigned SumW   = 36;
  localparam int unsigned RootW  = 18;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned DistW  = RootW + 1;
  localparam int unsigned DvW    = DistW + 1;
  localparam int unsigned NumW   = 32;
  localparam int unsigned QuotW  = 18;
  localparam int unsigned ResW   = 33;
  localparam int unsigned OutW   = 32;
  localparam int unsigned FracShift = 14;
  localparam int unsigned RndHalf   = 8192;
  localparam int unsigned SqShift   = 8;
  localparam int unsigned SqHalf    = 128;

  typedef enum logic [2:0] {
    RegEndAX    = 3'd0,
    RegEndAY    = 3'd1,
    RegEndAZ    = 3'd2,
    RegAxisX    = 3'd3,
    RegAxisY    = 3'd4,
    RegAxisZ    = 3'd5,
    RegAxisLen  = 3'd6,
    RegRadius   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][CoordW-1:0] end_a;
    logic [2:0][CoordW-1:0] axis;
    logic [LenW-1:0]        axis_length;
    logic [LenW-1:0]        cap_radius;
  } cfg_t;

  typedef struct packed {
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic                 square_mode;
  } side_t;

  typedef struct packed {
    logic        en;
    logic        valid;
  } flow_t;

endpackage

FILE: hdl/pcd_front.sv
module pcd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcd_pkg::flow_t                flow_i,
  input  pcd_pkg::cfg_t                 cfg_i,
  input  logic [2:0][pcd_pkg::CoordW-1:0] point_i,
  input  logic                          square_mode_i,
  output logic                          valid_o,
  output logic [pcd_pkg::SumW-1:0]      sum_o,
  output pcd_pkg::side_t                side_o
);

  localparam int unsigned NumSt = 7;

  logic [NumSt-1:0] v_q;

  logic [2:0][pcd_pkg::DiffW-1:0] d1_q, d2_q, d3_q, d4_q;
  logic [2:0][pcd_pkg::ProdW-1:0] p2_q;
  logic [pcd_pkg::LenW-1:0]       t3_q;
  logic [2:0][pcd_pkg::OffW-1:0]  q4_q;
  logic [2:0][pcd_pkg::RelW-1:0]  rel5_q;
  logic [2:0][pcd_pkg::SqW-1:0]   sq6_q;
  logic [pcd_pkg::SumW-1:0]       sum7_q;
  pcd_pkg::side_t                 side6_q, side7_q;
  logic [5:1]                     sm_q;

  logic [2:0][pcd_pkg::DiffW-1:0] d1_d;
  logic [2:0][pcd_pkg::ProdW-1:0] p2_d;
  logic [pcd_pkg::LenW-1:0]       t3_d;
  logic [2:0][pcd_pkg::OffW-1:0]  q4_d;
  logic [2:0][pcd_pkg::RelW-1:0]  rel5_d;
  logic [2:0][pcd_pkg::SqW-1:0]   sq6_d;
  logic [pcd_pkg::SumW-1:0]       sum7_d;
  pcd_pkg::side_t                 side6_d;
  logic signed [pcd_pkg::ProjW-1:0] proj, t_raw;
  logic signed [pcd_pkg::OffW-1:0]  off_full [3];
  logic signed [2*pcd_pkg::RelW-1:0] rel_sq [3];
  logic [pcd_pkg::RelW-1:0]         rel_abs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_d[i] = pcd_pkg::DiffW'($signed(point_i[i])) - pcd_pkg::DiffW'($signed(cfg_i.end_a[i]));
      p2_d[i] = $signed(d1_q[i]) * $signed(cfg_i.axis[i]);
      q4_d[i] = $signed({1'b0, t3_q}) * $signed(cfg_i.axis[i]);
      off_full[i] = ($signed(q4_q[i]) + $signed(pcd_pkg::OffW'(pcd_pkg::RndHalf)))
                  >>> pcd_pkg::FracShift;
      rel5_d[i] = pcd_pkg::RelW'($signed(d4_q[i])) - off_full[i][pcd_pkg::RelW-1:0];
      rel_sq[i] = $signed(rel5_q[i]) * $signed(rel5_q[i]);
      sq6_d[i] = rel_sq[i][pcd_pkg::SqW-1:0];
      rel_abs[i] = rel5_q[i][pcd_pkg::RelW-1] ? (~rel5_q[i] + 1'b1) : rel5_q[i];
      side6_d.mag[i] = rel_abs[i][pcd_pkg::MagW-1:0];
      side6_d.neg[i] = rel5_q[i][pcd_pkg::RelW-1];
    end
    side6_d.square_mode = sm_q[5];
    proj = pcd_pkg::ProjW'($signed(p2_q[0])) + pcd_pkg::ProjW'($signed(p2_q[1]))
         + pcd_pkg::ProjW'($signed(p2_q[2]));
    t_raw = (proj + $signed(pcd_pkg::ProjW'(pcd_pkg::RndHalf))) >>> pcd_pkg::FracShift;
    if (t_raw < 0) begin
      t3_d = '0;
    end else if (t_raw > $signed(pcd_pkg::ProjW'(cfg_i.axis_length))) begin
      t3_d = cfg_i.axis_length;
    end else begin
      t3_d = t_raw[pcd_pkg::LenW-1:0];
    end
    sum7_d = pcd_pkg::SumW'(sq6_q[0]) + pcd_pkg::SumW'(sq6_q[1]) + pcd_pkg::SumW'(sq6_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (flow_i.en) begin
      v_q <= {v_q[NumSt-2:0], flow_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.en) begin
      d1_q    <= d1_d;
      sm_q[1] <= square_mode_i;
      d2_q    <= d1_q;
      p2_q    <= p2_d;
      sm_q[2] <= sm_q[1];
      d3_q    <= d2_q;
      t3_q    <= t3_d;
      sm_q[3] <= sm_q[2];
      d4_q    <= d3_q;
      q4_q    <= q4_d;
      sm_q[4] <= sm_q[3];
      rel5_q  <= rel5_d;
      sm_q[5] <= sm_q[4];
      sq6_q   <= sq6_d;
      side6_q <= side6_d;
      sum7_q  <= sum7_d;
      side7_q <= side6_q;
    end
  end

  assign valid_o = v_q[NumSt-1];
  assign sum_o   = sum7_q;
  assign side_o  = side7_q;

endmodule

FILE: hdl/pcd_sqrt.sv
module pcd_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pcd_pkg::flow_t             flow_i,
  input  logic [pcd_pkg::SumW-1:0]   sum_i,
  input  pcd_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [pcd_pkg::RootW-1:0]  root_o,
  output logic [pcd_pkg::RemW-1:0]   rem_o,
  output pcd_pkg::side_t             side_o
);

  localparam int unsigned NumSt = pcd_pkg::RootW;

  logic [NumSt-1:0]          v_q;
  logic [pcd_pkg::SumW-1:0]  x_q    [NumSt];
  logic [pcd_pkg::RemW-1:0]  rem_q  [NumSt];
  logic [pcd_pkg::RootW-1:0] root_q [NumSt];
  pcd_pkg::side_t            side_q [NumSt];

  logic [pcd_pkg::SumW-1:0]  x_d    [NumSt];
  logic [pcd_pkg::RemW-1:0]  rem_d  [NumSt];
  logic [pcd_pkg::RootW-1:0] root_d [NumSt];

  always_comb begin
    logic [pcd_pkg::SumW-1:0]  xin;
    logic [pcd_pkg::RemW-1:0]  rin;
    logic [pcd_pkg::RootW-1:0] qin;
    logic [pcd_pkg::RemW+1:0]  trial, tval;
    for (int k = 0; k < NumSt; k++) begin
      xin = (k == 0) ? sum_i : x_q[(k == 0) ? 0 : k-1];
      rin = (k == 0) ? '0 : rem_q[(k == 0) ? 0 : k-1];
      qin = (k == 0) ? '0 : root_q[(k == 0) ? 0 : k-1];
      tval  = {rin, xin[pcd_pkg::SumW-1 -: 2]};
      trial = (pcd_pkg::RemW+2)'({qin, 2'b01});
      if (tval >= trial) begin
        rem_d[k]  = pcd_pkg::RemW'(tval - trial);
        root_d[k] = {qin[pcd_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d[k]  = tval[pcd_pkg::RemW-1:0];
        root_d[k] = {qin[pcd_pkg::RootW-2:0], 1'b0};
      end
      x_d[k] = {xin[pcd_pkg::SumW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (flow_i.en) begin
      v_q <= {v_q[NumSt-2:0], flow_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.en) begin
      for (int k = 0; k < NumSt; k++) begin
        x_q[k]    <= x_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= (k == 0) ? side_i : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign valid_o = v_q[NumSt-1];
  assign root_o  = root_q[NumSt-1];
  assign rem_o   = rem_q[NumSt-1];
  assign side_o  = side_q[NumSt-1];

endmodule

FILE: hdl/pcd_div.sv
module pcd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcd_pkg::flow_t                    flow_i,
  input  logic [pcd_pkg::LenW-1:0]          cap_radius_i,
  input  logic [pcd_pkg::RootW-1:0]         root_i,
  input  logic [pcd_pkg::RemW-1:0]          rem_i,
  input  pcd_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic [2:0][pcd_pkg::QuotW-1:0]    quot_o,
  output logic [2:0]                        neg_o,
  output logic                              zero_o,
  output logic [pcd_pkg::ResW-1:0]          res_o
);

  localparam int unsigned NumSt = pcd_pkg::QuotW + 1;
  localparam int unsigned LowW  = pcd_pkg::QuotW;
  localparam int unsigned HighW = pcd_pkg::NumW - LowW;
  localparam int unsigned OutWSq = 2 * pcd_pkg::DvW;

  logic [NumSt-1:0]                    v_q;
  logic [pcd_pkg::DistW-1:0]           len_q  [NumSt];
  logic [2:0][pcd_pkg::DistW-1:0]      rem_q  [NumSt];
  logic [2:0][LowW-1:0]                low_q  [NumSt];
  logic [2:0][pcd_pkg::QuotW-1:0]      quo_q  [NumSt];
  logic [2:0]                          neg_q  [NumSt];
  logic                                zero_q [NumSt];
  logic                                sm_q   [NumSt];
  logic [pcd_pkg::DvW-1:0]             dv_q;
  logic [pcd_pkg::ResW-1:0]            res_q  [NumSt];

  logic [pcd_pkg::DistW-1:0]           len_d;
  logic [2:0][pcd_pkg::NumW-1:0]       num_d;
  logic [pcd_pkg::DvW-1:0]             dv_d;
  logic [2:0][pcd_pkg::DistW-1:0]      rem_d  [NumSt];
  logic [2:0][LowW-1:0]                low_d  [NumSt];
  logic [2:0][pcd_pkg::QuotW-1:0]      quo_d  [NumSt];
  logic [pcd_pkg::ResW-1:0]            res_d;

  always_comb begin
    logic signed [2*pcd_pkg::DvW-1:0] dsq;
    logic [OutWSq-1:0]               sqm;
    logic [pcd_pkg::DistW:0]         tval;
    len_d = pcd_pkg::DistW'(root_i)
          + pcd_pkg::DistW'(rem_i > pcd_pkg::RemW'(root_i));
    dv_d  = $signed(pcd_pkg::DvW'(len_d)) - $signed(pcd_pkg::DvW'(cap_radius_i));
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (pcd_pkg::NumW'(side_i.mag[i]) << pcd_pkg::FracShift)
               + pcd_pkg::NumW'(len_d >> 1);
      rem_d[0][i] = pcd_pkg::DistW'(num_d[i][pcd_pkg::NumW-1 -: HighW]);
      low_d[0][i] = num_d[i][LowW-1:0];
      quo_d[0][i] = '0;
    end
    for (int k = 1; k < NumSt; k++) begin
      for (int i = 0; i < 3; i++) begin
        tval = {rem_q[k-1][i], low_q[k-1][i][LowW-1]};
        if (tval >= {1'b0, len_q[k-1]}) begin
          rem_d[k][i] = pcd_pkg::DistW'(tval - {1'b0, len_q[k-1]});
          quo_d[k][i] = {quo_q[k-1][i][pcd_pkg::QuotW-2:0], 1'b1};
        end else begin
          rem_d[k][i] = tval[pcd_pkg::DistW-1:0];
          quo_d[k][i] = {quo_q[k-1][i][pcd_pkg::QuotW-2:0], 1'b0};
        end
        low_d[k][i] = {low_q[k-1][i][LowW-2:0], 1'b0};
      end
    end
    dsq = $signed(dv_q) * $signed(dv_q);
    sqm = OutWSq'((OutWSq'(dsq) + OutWSq'(pcd_pkg::SqHalf)) >> pcd_pkg::SqShift);
    if (sm_q[0]) begin
      res_d = dv_q[pcd_pkg::DvW-1] ? pcd_pkg::ResW'(-$signed({1'b0, sqm}))
                                    : pcd_pkg::ResW'({1'b0, sqm});
    end else begin
      res_d = pcd_pkg::ResW'($signed(dv_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (flow_i.en) begin
      v_q <= {v_q[NumSt-2:0], flow_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.en) begin
      len_q[0]  <= len_d;
      neg_q[0]  <= side_i.neg;
      zero_q[0] <= (len_d == '0);
      sm_q[0]   <= side_i.square_mode;
      dv_q      <= dv_d;
      res_q[0]  <= '0;
      for (int k = 0; k < NumSt; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
      end
      for (int k = 1; k < NumSt; k++) begin
        len_q[k]  <= len_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        sm_q[k]   <= sm_q[k-1];
        res_q[k]  <= (k == 1) ? res_d : res_q[k-1];
      end
    end
  end

  assign valid_o = v_q[NumSt-1];
  assign quot_o  = quo_q[NumSt-1];
  assign neg_o   = neg_q[NumSt-1];
  assign zero_o  = zero_q[NumSt-1];
  assign res_o   = res_q[NumSt-1];

endmodule

FILE: hdl/point_capsule_distance.sv
// channel  dir  handshake                 words
// in       in   in_valid_i / in_ready_o   point_x_i point_y_i point_z_i square_mode_i
// out      out  out_valid_o / out_ready_i dist_value_o normal_x_o normal_y_o normal_z_o
//                                          saturated_o
// cfg      in   cfg_we_i                  cfg_idx_i cfg_wdata_i
// One word enters per cycle unless the skid register is full; 7 projection stages, 18 square
// root stages, 19 divider stages (one setup, one per quotient bit), one output register.
// Reset clears all valid bits and loads the register reset values.
// A stalled output fills a one-word skid register; the pipeline halts only while it is full.
module point_capsule_distance (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  input  logic [15:0] point_z_i,
  input  logic        square_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] dist_value_o,
  output logic [15:0] normal_x_o,
  output logic [15:0] normal_y_o,
  output logic [15:0] normal_z_o,
  output logic        saturated_o
);

  typedef struct packed {
    logic [pcd_pkg::OutW-1:0]          dval;
    logic [2:0][pcd_pkg::CoordW-1:0]   nrm;
    logic                              sat;
  } word_t;

  pcd_pkg::cfg_t  cfg_q;
  pcd_pkg::flow_t flow_in, flow_sq, flow_dv;
  logic           en;

  logic                            f_valid;
  logic [pcd_pkg::SumW-1:0]        f_sum;
  pcd_pkg::side_t                  f_side, s_side;
  logic                            s_valid;
  logic [pcd_pkg::RootW-1:0]       s_root;
  logic [pcd_pkg::RemW-1:0]        s_rem;
  logic                            d_valid;
  logic [2:0][pcd_pkg::QuotW-1:0]  d_quot;
  logic [2:0]                      d_neg;
  logic                            d_zero;
  logic [pcd_pkg::ResW-1:0]        d_res;

  word_t res_word;
  word_t out_q, skid_q;
  logic  out_v_q, skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_a       <= '0;
      cfg_q.axis        <= {16'd0, 16'd0, 16'd16384};
      cfg_q.axis_length <= '0;
      cfg_q.cap_radius  <= 15'd256;
    end else if (cfg_we_i) begin
      unique case (pcd_pkg::reg_idx_e'(cfg_idx_i))
        pcd_pkg::RegEndAX:   cfg_q.end_a[0]     <= cfg_wdata_i;
        pcd_pkg::RegEndAY:   cfg_q.end_a[1]     <= cfg_wdata_i;
        pcd_pkg::RegEndAZ:   cfg_q.end_a[2]     <= cfg_wdata_i;
        pcd_pkg::RegAxisX:   cfg_q.axis[0]      <= cfg_wdata_i;
        pcd_pkg::RegAxisY:   cfg_q.axis[1]      <= cfg_wdata_i;
        pcd_pkg::RegAxisZ:   cfg_q.axis[2]      <= cfg_wdata_i;
        pcd_pkg::RegAxisLen: cfg_q.axis_length  <= cfg_wdata_i[pcd_pkg::LenW-1:0];
        pcd_pkg::RegRadius:  cfg_q.cap_radius   <= cfg_wdata_i[pcd_pkg::LenW-1:0];
        default:             cfg_q.cap_radius   <= cfg_q.cap_radius;
      endcase
    end
  end

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign flow_in    = '{en: en, valid: in_valid_i};
  assign flow_sq    = '{en: en, valid: f_valid};
  assign flow_dv    = '{en: en, valid: s_valid};

  pcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .flow_i        (flow_in),
    .cfg_i         (cfg_q),
    .point_i       ({point_z_i, point_y_i, point_x_i}),
    .square_mode_i (square_mode_i),
    .valid_o       (f_valid),
    .sum_o         (f_sum),
    .side_o        (f_side)
  );

  pcd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flow_i  (flow_sq),
    .sum_i   (f_sum),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .rem_o   (s_rem),
    .side_o  (s_side)
  );

  pcd_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flow_i       (flow_dv),
    .cap_radius_i (cfg_q.cap_radius),
    .root_i       (s_root),
    .rem_i        (s_rem),
    .side_i       (s_side),
    .valid_o      (d_valid),
    .quot_o       (d_quot),
    .neg_o        (d_neg),
    .zero_o       (d_zero),
    .res_o        (d_res)
  );

  always_comb begin
    logic [pcd_pkg::QuotW-1:0] qs;
    for (int i = 0; i < 3; i++) begin
      qs = d_neg[i] ? (~d_quot[i] + 1'b1) : d_quot[i];
      res_word.nrm[i] = d_zero ? '0 : qs[pcd_pkg::CoordW-1:0];
    end
    res_word.sat = d_res[pcd_pkg::ResW-1] != d_res[pcd_pkg::ResW-2];
    if (!res_word.sat) begin
      res_word.dval = d_res[pcd_pkg::OutW-1:0];
    end else if (d_res[pcd_pkg::ResW-1]) begin
      res_word.dval = {1'b1, {(pcd_pkg::OutW-1){1'b0}}};
    end else begin
      res_word.dval = {1'b0, {(pcd_pkg::OutW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= d_valid;
      end
    end else if (d_valid && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : res_word;
    end else if (d_valid && en) begin
      skid_q <= res_word;
    end
  end

  assign out_valid_o  = out_v_q;
  assign dist_value_o = out_q.dval;
  assign normal_x_o   = out_q.nrm[0];
  assign normal_y_o   = out_q.nrm[1];
  assign normal_z_o   = out_q.nrm[2];
  assign saturated_o  = out_q.sat;

endmodule

FILE: tb/point_capsule_distance_tb.sv
module point_capsule_distance_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic        sq;
  } query_t;

  typedef struct packed {
    logic [31:0] dval;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        sat;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] point_x_i = '0;
  logic [15:0] point_y_i = '0;
  logic [15:0] point_z_i = '0;
  logic        square_mode_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] dist_value_o;
  logic [15:0] normal_x_o;
  logic [15:0] normal_y_o;
  logic [15:0] normal_z_o;
  logic        saturated_o;

  point_capsule_distance i_dut (.*);

  always #1 clk_i = ~clk_i;

  logic signed [15:0] cap_end [3];
  logic signed [15:0] cap_axis [3];
  logic [14:0]        cap_len;
  logic [14:0]        cap_rad;

  query_t  pending_q [$];
  answer_t dist_q [$];
  int      errors = 0;
  int      n_queued = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_square = 0;
  bit      calm = 1'b0;
  bit      hold_send = 1'b0;
  bit      in_took = 1'b0;

  function automatic longint rnd_shr14(longint v);
    longint w;
    w = v + 8192;
    return w >>> 14;
  endfunction

  function automatic longint root_round(longint s);
    longint r;
    longint b;
    longint x;
    r = 0;
    x = s;
    b = longint'(1) << 60;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic answer_t capsule_distance(query_t q);
    answer_t a;
    longint d [3];
    longint rel [3];
    longint nrm [3];
    longint proj;
    longint t;
    longint s;
    longint len;
    longint dv;
    longint res;
    longint mag;
    longint sqv;
    logic signed [15:0] p [3];
    p[0] = q.px;
    p[1] = q.py;
    p[2] = q.pz;
    proj = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(p[i]) - longint'(cap_end[i]);
      proj += d[i] * longint'(cap_axis[i]);
    end
    t = rnd_shr14(proj);
    if (t < 0) t = 0;
    if (t > longint'(cap_len)) t = longint'(cap_len);
    s = 0;
    for (int i = 0; i < 3; i++) begin
      rel[i] = d[i] - rnd_shr14(t * longint'(cap_axis[i]));
      s += rel[i] * rel[i];
    end
    len = root_round(s);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        nrm[i] = 0;
      end else begin
        mag = rel[i] < 0 ? -rel[i] : rel[i];
        nrm[i] = (mag * 16384 + len / 2) / len;
        if (rel[i] < 0) nrm[i] = -nrm[i];
      end
    end
    dv = len - longint'(cap_rad);
    if (q.sq) begin
      sqv = (dv * dv + 128) >> 8;
      res = dv < 0 ? -sqv : sqv;
    end else begin
      res = dv;
    end
    a.sat = 1'b0;
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      a.sat = 1'b1;
    end else if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      a.sat = 1'b1;
    end
    a.dval = res[31:0];
    a.nx = nrm[0][15:0];
    a.ny = nrm[1][15:0];
    a.nz = nrm[2][15:0];
    return a;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (pending_q.size() > 0 && !hold_send && (calm || $urandom_range(99) >= 35)) begin
          query_t q;
          q = pending_q.pop_front();
          in_valid_i <= 1'b1;
          point_x_i <= q.px;
          point_y_i <= q.py;
          point_z_i <= q.pz;
          square_mode_i <= q.sq;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= calm || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && in_ready_o;
    if (in_took) begin
      dist_q.push_back(capsule_distance({point_x_i, point_y_i, point_z_i, square_mode_i}));
      n_sent++;
      if (square_mode_i) n_square++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dist_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word dist=%h", $time, dist_value_o);
      end else begin
        answer_t e;
        e = dist_q.pop_front();
        n_checked++;
        if (e.dval !== dist_value_o) begin
          errors++;
          $display("%0t: dist expected %h actual %h", $time, e.dval, dist_value_o);
        end
        if (e.nx !== normal_x_o) begin
          errors++;
          $display("%0t: normal_x expected %h actual %h", $time, e.nx, normal_x_o);
        end
        if (e.ny !== normal_y_o) begin
          errors++;
          $display("%0t: normal_y expected %h actual %h", $time, e.ny, normal_y_o);
        end
        if (e.nz !== normal_z_o) begin
          errors++;
          $display("%0t: normal_z expected %h actual %h", $time, e.nz, normal_z_o);
        end
        if (e.sat !== saturated_o) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated_o);
        end
      end
    end
  end

  task automatic write_reg(pcd_pkg::reg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pcd_pkg::RegEndAX, pcd_pkg::RegEndAY, pcd_pkg::RegEndAZ: cap_end[int'(idx)] = val;
      pcd_pkg::RegAxisX, pcd_pkg::RegAxisY, pcd_pkg::RegAxisZ: cap_axis[int'(idx) - 3] = val;
      pcd_pkg::RegAxisLen: cap_len = val[14:0];
      default: cap_rad = val[14:0];
    endcase
  endtask

  task automatic drain();
    wait (n_sent == n_queued && dist_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic add_query(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic sq);
    query_t q;
    q.px = x;
    q.py = y;
    q.pz = z;
    q.sq = sq;
    pending_q.push_back(q);
    n_queued++;
  endtask

  function automatic logic [15:0] rnd_unit();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'sd11585;
      4: return -16'sd11585;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(4095)) - 16'd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config(int sel);
    write_reg(pcd_pkg::RegEndAX, sel == 0 ? 16'h8000 : sel == 1 ? 16'h7fff : rnd_coord());
    write_reg(pcd_pkg::RegEndAY, sel == 0 ? 16'h8000 : sel == 1 ? 16'h7fff : rnd_coord());
    write_reg(pcd_pkg::RegEndAZ, sel == 0 ? 16'h8000 : sel == 1 ? 16'h7fff : rnd_coord());
    write_reg(pcd_pkg::RegAxisX, rnd_unit());
    write_reg(pcd_pkg::RegAxisY, sel == 0 ? -16'sd16384 : rnd_unit());
    write_reg(pcd_pkg::RegAxisZ, sel == 1 ? 16'sd16384 : rnd_unit());
    write_reg(pcd_pkg::RegAxisLen,
              sel == 0 ? 16'h7fff : sel == 1 ? 16'h0000 : 16'($urandom_range(32767)));
    write_reg(pcd_pkg::RegRadius,
              sel == 0 ? 16'h7fff : sel == 1 ? 16'h0000 : 16'($urandom_range(32767)));
  endtask

  initial begin
    cap_end = '{default: 16'sd0};
    cap_axis = '{16'sd16384, 16'sd0, 16'sd0};
    cap_len = '0;
    cap_rad = 15'd256;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_query(16'd0, 16'd0, 16'd0, 1'b0);
    add_query(16'd0, 16'd0, 16'd0, 1'b1);
    add_query(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    add_query(16'h8000, 16'h8000, 16'h8000, 1'b1);
    add_query(16'h7fff, 16'h8000, 16'h0100, 1'b1);
    add_query(16'h0100, 16'h0000, 16'h0000, 1'b0);
    drain();

    write_reg(pcd_pkg::RegEndAX, 16'hff00);
    write_reg(pcd_pkg::RegAxisLen, 16'h0400);
    write_reg(pcd_pkg::RegRadius, 16'h0080);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pcd_pkg::RegAxisX;
    cfg_wdata_i <= 16'sd16384;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    add_query(16'h0100, 16'h0000, 16'h0000, 1'b0);
    add_query(16'h0200, 16'h0000, 16'h0000, 1'b1);
    add_query(16'h0600, 16'h0300, 16'h0000, 1'b0);
    add_query(16'hf000, 16'h0000, 16'h0400, 1'b1);
    add_query(16'h0000, 16'h0040, 16'h0000, 1'b0);
    add_query(16'h0000, 16'h0040, 16'h0000, 1'b1);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      random_config(phase);
      write_reg(pcd_pkg::RegAxisX, 16'($signed($urandom_range(40000)) - 20000));
      if (phase == 4) calm = 1'b1;
      if (phase == 5) calm = 1'b0;
      for (int k = 0; k < 60; k++) begin
        if (k == 30 && phase == 2) begin
          wait (pending_q.size() == 0);
          hold_send = 1'b1;
          wait (n_sent == n_queued && dist_q.size() == 0);
          hold_send = 1'b0;
        end
        if ($urandom_range(3) == 0)
          add_query(cap_end[0] + 16'($urandom_range(3)), cap_end[1], cap_end[2], 1'($urandom));
        else
          add_query(rnd_coord(), rnd_coord(), rnd_coord(), 1'($urandom));
      end
      drain();
    end

    $display("covered %0d queries (%0d squared) over 12 capsule settings, %0d checked",
             n_sent, n_square, n_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
